### sv/divisor_count_unit_defines.svh
// assertion macros shared by the divisor count unit
`ifndef DIVISOR_COUNT_UNIT_DEFINES_SVH
`define DIVISOR_COUNT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define DCU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dcu check failed");
// checked on every rising clock edge, reset included
`define DCU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("dcu check failed");
`else
`define DCU_ASSERT(lbl, clk, rst_n, prop)
`define DCU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/dcu_pkg.sv
// shared constants and types of the divisor count unit
`timescale 1ns / 1ps
package dcu_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_W       = 11;
    localparam int DIV_W       = VALUE_WIDTH / 2 + 1;
    localparam int SQ_W        = VALUE_WIDTH + 1;
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_WIDTH - 1);
    localparam logic [OUT_W-1:0]  ZERO_TOTAL = OUT_W'(2);
    localparam logic [OUT_W-1:0]  MAX_TOTAL  = OUT_W'(1600);

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [DIV_W-1:0]       divisor;
    } t_rem_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic is_zero;
    } t_rem_stat;
endpackage

### sv/dcu_rem_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module dcu_rem_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcu_pkg::t_rem_req  i_req,
    output dcu_pkg::t_rem_stat o_stat
);
    import dcu_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_step;
    logic [VALUE_WIDTH-1:0] r_num;
    logic [DIV_W-1:0]       r_div;
    logic [DIV_W-1:0]       r_rem;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_num[VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, r_div};
        fits    = shifted >= {1'b0, r_div};
        n_rem   = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= STEP_LAST;
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[VALUE_WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.done    = r_done;
    assign o_stat.is_zero = (r_rem == '0);
endmodule

### sv/divisor_count_unit.sv
// top level of the divisor count unit: sequencer over candidate divisors
//
// takes one signed 32-bit word and returns the number of positive divisors of
// its magnitude (magnitude one gives 1, zero gives 2, the most negative value
// is read as 2^31). candidates d = 1, 2, ... are tried while d*d does not exceed
// the magnitude; each divisor found adds two (one for a perfect square root).
// d*d is kept by adding 2d+1, so no multiplier is needed. every candidate goes
// through one shared bit-serial remainder unit; the bound is tested before each
// candidate and the remainder is folded into the count once it is done. the
// unit takes one word at a time and is not ready while it works. the result
// sits in an output register, so a new word is taken while the last result
// still waits; a finished count waits only if the previous result has not
// yet been taken.
`timescale 1ns / 1ps
`include "divisor_count_unit_defines.svh"
module divisor_count_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [dcu_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dcu_pkg::OUT_W-1:0]       o_divisor_total
);
    import dcu_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;

    logic [1:0]             r_state;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [DIV_W-1:0]       r_d;
    logic [SQ_W-1:0]        r_sq;
    logic [OUT_W-1:0]       r_count;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out;

    logic [VALUE_WIDTH-1:0] mag_in;
    logic                   past_bound;
    logic                   out_free;
    logic                   finish;
    logic [OUT_W-1:0]       final_total;
    t_rem_req               rem_req;
    t_rem_stat              rem_stat;

    // magnitude; the most negative word wraps to 2^(w-1) as unsigned
    always_comb begin
        mag_in = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
    end

    // candidate loop ends once d*d passes the magnitude (zero ends at once)
    assign past_bound  = (r_mag == '0) || (r_sq > {1'b0, r_mag});
    assign out_free    = !r_out_valid || i_out_ready;
    assign finish      = (r_state == S_CHECK) && past_bound && out_free;
    assign final_total = (r_mag == '0) ? ZERO_TOTAL : r_count;

    assign rem_req.start    = (r_state == S_CHECK) && !past_bound;
    assign rem_req.dividend = r_mag;
    assign rem_req.divisor  = r_d;

    dcu_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_stat  (rem_stat)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end else if (!past_bound) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_stat.done) begin
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // candidate, its square and the running count
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_mag   <= mag_in;
            r_d     <= DIV_W'(1);
            r_sq    <= SQ_W'(1);
            r_count <= '0;
        end else if (r_state == S_DIV && rem_stat.done) begin
            if (rem_stat.is_zero) begin
                // a root that is exact counts once, other divisors pair up
                r_count <= r_count + ((r_sq == {1'b0, r_mag}) ? OUT_W'(1) : OUT_W'(2));
            end
            r_d  <= r_d + 1'b1;
            r_sq <= r_sq + SQ_W'({r_d, 1'b1});
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= final_total;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_divisor_total = r_out;

    // remainder unit is idle whenever a new word can be taken
    `DCU_ASSERT(a_idle_rem_free, i_clk, i_rst_n, o_in_ready |-> !rem_stat.busy)
    // a remainder only completes while the sequencer waits for it
    `DCU_ASSERT(a_done_in_div, i_clk, i_rst_n, rem_stat.done |-> (r_state == S_DIV))
    // running count never exceeds the most divisors a 32-bit magnitude can have
    `DCU_ASSERT(a_count_bound, i_clk, i_rst_n, (r_state == S_IDLE) || (r_count <= MAX_TOTAL))
    // a finished count is only loaded when the output register can take it
    `DCU_ASSERT(a_no_overwrite, i_clk, i_rst_n, finish |-> (!r_out_valid || i_out_ready))
    // reset leaves no result pending
    `DCU_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)
endmodule

### tb/sv/divisor_count_unit_tb.sv
// self-checking testbench for the divisor count unit
`timescale 1ns / 1ps
module divisor_count_unit_tb;
    import dcu_pkg::*;

    // the quiet-cycle limit leaves a wide margin over the longest correct item,
    // which comes with |value| near 2^31
    localparam int QUIET_LIMIT   = 10_000_000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_WORDS  = 100;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] word;
        logic [OUT_W-1:0]       total;
    } t_expected_total;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [OUT_W-1:0]              o_divisor_total;

    t_expected_total pending_totals[$];
    int              error_count = 0;
    int              quiet_cycles = 0;
    int              burst_left = 0;
    bit              gaps_on = 1'b0;
    int              ready_run = 0;

    divisor_count_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_divisor_total (o_divisor_total)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // divisor count of |word|, with |most negative| read as 2^(w-1)
    function automatic logic [OUT_W-1:0] divisor_total_of(input logic [VALUE_WIDTH-1:0] word);
        logic [VALUE_WIDTH-1:0] abs_word;
        longint unsigned        mag;
        longint unsigned        d;
        longint unsigned        total;
        abs_word = word[VALUE_WIDTH-1] ? -word : word;
        mag      = longint'(abs_word);
        if (mag == 0) begin
            return ZERO_TOTAL;
        end
        total = 0;
        // divisors come in pairs around the square root
        for (d = 1; d * d <= mag; d++) begin
            if (mag % d == 0) begin
                total += (d * d == mag) ? 1 : 2;
            end
        end
        return total[OUT_W-1:0];
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // drive one word at a falling edge, hold it until taken
    task automatic send_value(input logic [VALUE_WIDTH-1:0] word);
        t_expected_total want;
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_value    <= word;
        do @(posedge i_clk); while (!o_in_ready);
        want.word  = word;
        want.total = divisor_total_of(word);
        pending_totals.push_back(want);
    endtask

    // zero, unit magnitudes, squares, primes, powers of two, a highly
    // composite value, both signs
    task automatic test_corner_values();
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sd2);
        send_value(-32'sd2);
        send_value(32'sd3);
        send_value(32'sd4);
        send_value(-32'sd4);
        send_value(32'sd36);
        send_value(32'sd97);
        send_value(-32'sd97);
        send_value(32'sd1024);
        send_value(-32'sd1023);
        send_value(32'sd720720);
        send_value(-32'sd720720);
    endtask

    // range ends, the most negative word and the largest possible count
    task automatic test_field_extremes();
        gaps_on = 1'b1;
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0001);
        send_value(32'sh8000_0000);
        send_value(32'sd2095133040);
    endtask

    // mostly small magnitudes so the run stays short; random sign drives
    // every upper bit both ways
    task automatic test_random_values();
        int                     n;
        int                     pick;
        int                     mag;
        int                     root;
        logic [VALUE_WIDTH-1:0] word;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            // first stretch back to back, then bursts with gaps
            gaps_on = (n >= 30);
            pick    = $urandom_range(0, 19);
            if (pick < 13) begin
                mag = $urandom_range(0, 4095);
            end else if (pick < 17) begin
                mag = $urandom_range(4096, 262143);
            end else if (pick < 19) begin
                root = $urandom_range(2, 300);
                mag  = root * root;
            end else begin
                mag = 1 << $urandom_range(0, 18);
            end
            word = $urandom_range(0, 1) ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
            send_value(word);
        end
    endtask

    // receiver: alternating ready and stall runs, some long ready stretches
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            if (i_out_ready) begin
                i_out_ready <= 1'b0;
                ready_run = $urandom_range(1, 20);
            end else begin
                i_out_ready <= 1'b1;
                ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                        : $urandom_range(1, 15);
            end
        end else begin
            ready_run--;
        end
    end

    // result checker: each taken result against the oldest expectation
    always @(posedge i_clk) begin
        t_expected_total want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_totals.size() == 0) begin
                note_error($sformatf("unexpected result divisor_total=%0d", o_divisor_total));
            end else begin
                want = pending_totals.pop_front();
                if (o_divisor_total !== want.total) begin
                    note_error($sformatf("value=%0d divisor_total expected %0d got %0d",
                                         $signed(want.word), want.total, o_divisor_total));
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_values();
        test_random_values();
        test_field_extremes();

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending_totals.size() != 0) @(posedge i_clk);
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_totals.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/dcu_pkg.sv
sv/dcu_rem_unit.sv
sv/divisor_count_unit.sv
tb/sv/divisor_count_unit_tb.sv
